// ===== sv/pdtgf_pkg.sv =====
package pdtgf_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int COS_ADDR_BITS   = 10;
    localparam int COS_TABLE_DEPTH = 1 << COS_ADDR_BITS;
    localparam int COS_W           = FRAC_BITS + 1;

    localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_COEFF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION_COEFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA_COEFF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE    = 3'd5;

    // multiplier operand selection
    localparam logic [2:0] MUL_DV    = 3'd0;
    localparam logic [2:0] MUL_ANG   = 3'd1;
    localparam logic [2:0] MUL_INER  = 3'd2;
    localparam logic [2:0] MUL_FRIC  = 3'd3;
    localparam logic [2:0] MUL_GRAV  = 3'd4;
    localparam logic [2:0] MUL_PROP  = 3'd5;
    localparam logic [2:0] MUL_DERIV = 3'd6;

    typedef struct packed {
        logic       in_ld;
        logic [2:0] mul_sel;
        logic       accel_ld;
        logic       idx_ld;
        logic       rom_rd;
        logic       acc_first;
        logic       acc_add;
        logic       out_ld;
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } stat_t;

    typedef logic [COS_W-1:0] cos_tab_t [0:COS_TABLE_DEPTH];

    // restoring division, only evaluated while the table is built
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            r = (r << 1) | {63'd0, num[b]};
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // quarter-wave cosine, taylor series in q30, rounded to FRAC_BITS
    function automatic cos_tab_t build_cos_tab();
        cos_tab_t        tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned e;
        for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * longint'(k)) >> COS_ADDR_BITS;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = longint'(term);
            for (int n = 1; n <= 12; n++) begin
                term = udiv((term * x2) >> 30, longint'((2 * n - 1) * (2 * n)));
                if ((n & 1) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            e = (longint'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
            tab[k] = e[COS_W-1:0];
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

// ===== sv/pdtgf_ctrl.sv =====
module pdtgf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             out_ready,
    input  pdtgf_pkg::stat_t stat,
    output pdtgf_pkg::cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DV    = 4'd1;
    localparam logic [3:0] ST_ANG   = 4'd2;
    localparam logic [3:0] ST_INER  = 4'd3;
    localparam logic [3:0] ST_FRIC  = 4'd4;
    localparam logic [3:0] ST_GRAV  = 4'd5;
    localparam logic [3:0] ST_PROP  = 4'd6;
    localparam logic [3:0] ST_DERIV = 4'd7;
    localparam logic [3:0] ST_FINAL = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_ld  = 1'b1;
                    state_next = ST_DV;
                end
            end
            ST_DV:
            begin
                cmd.mul_sel = pdtgf_pkg::MUL_DV;
                state_next  = ST_ANG;
            end
            ST_ANG:
            begin
                cmd.mul_sel  = pdtgf_pkg::MUL_ANG;
                cmd.accel_ld = 1'b1;
                state_next   = ST_INER;
            end
            ST_INER:
            begin
                cmd.mul_sel = pdtgf_pkg::MUL_INER;
                cmd.idx_ld  = 1'b1;
                state_next  = ST_FRIC;
            end
            ST_FRIC:
            begin
                cmd.mul_sel   = pdtgf_pkg::MUL_FRIC;
                cmd.rom_rd    = 1'b1;
                cmd.acc_first = 1'b1;
                state_next    = ST_GRAV;
            end
            ST_GRAV:
            begin
                cmd.mul_sel = pdtgf_pkg::MUL_GRAV;
                cmd.acc_add = 1'b1;
                state_next  = ST_PROP;
            end
            ST_PROP:
            begin
                cmd.mul_sel = pdtgf_pkg::MUL_PROP;
                cmd.acc_add = 1'b1;
                state_next  = ST_DERIV;
            end
            ST_DERIV:
            begin
                cmd.mul_sel = pdtgf_pkg::MUL_DERIV;
                cmd.acc_add = 1'b1;
                state_next  = ST_FINAL;
            end
            ST_FINAL:
            begin
                // keep the derivative product steady while waiting
                cmd.mul_sel = pdtgf_pkg::MUL_DERIV;
                // hold until the output register is free
                if (!stat.out_full || out_ready)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/pdtgf_datapath.sv =====
module pdtgf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pdtgf_pkg::cmd_t                     cmd,
    output pdtgf_pkg::stat_t                    stat,
    input  logic [127:0]                        in_data,
    input  logic                                cfg_valid,
    input  logic [pdtgf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                         cfg_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [31:0]                         out_torque,
    output logic                                out_sat
);

    localparam int F  = pdtgf_pkg::FRAC_BITS;
    localparam int L  = pdtgf_pkg::COS_ADDR_BITS;
    localparam int CW = pdtgf_pkg::COS_W;

    logic [31:0] prop_gain_reg, deriv_gain_reg, gravity_reg, friction_reg, inertia_reg;
    logic [15:0] rate_reg;
    logic [31:0] last_vel_reg;

    logic signed [31:0] angle_reg, vel_reg;
    logic signed [32:0] dv_reg, ea_reg, ev_reg;
    logic signed [33:0] accel_reg;
    logic        [L:0]  idx_reg;
    logic        [1:0]  quad_reg;
    logic      [CW-1:0] rom_q_reg;
    logic signed [66:0] prod_reg;
    logic signed [53:0] acc_reg;
    logic               out_valid_reg;
    logic        [31:0] torque_reg;
    logic               sat_reg;

    logic signed [31:0] in_angle, in_vel, in_angle_t, in_vel_t;
    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [CW:0] cos_val;
    logic        [31:0] frac;
    logic        [L:0]  rom_addr;
    logic signed [50:0] term;
    logic signed [53:0] acc_sum;

    assign in_angle   = in_data[31:0];
    assign in_vel     = in_data[63:32];
    assign in_angle_t = in_data[95:64];
    assign in_vel_t   = in_data[127:96];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= 32'd65536;
            deriv_gain_reg <= 32'd131072;
            gravity_reg    <= 32'd77070;
            friction_reg   <= 32'd6554;
            inertia_reg    <= 32'd2359;
            rate_reg       <= 16'd500;
            last_vel_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    pdtgf_pkg::REG_PROP_GAIN:      prop_gain_reg  <= cfg_data;
                    pdtgf_pkg::REG_DERIV_GAIN:     deriv_gain_reg <= cfg_data;
                    pdtgf_pkg::REG_GRAVITY_COEFF:  gravity_reg    <= cfg_data;
                    pdtgf_pkg::REG_FRICTION_COEFF: friction_reg   <= cfg_data;
                    pdtgf_pkg::REG_INERTIA_COEFF:  inertia_reg    <= cfg_data;
                    pdtgf_pkg::REG_SAMPLE_RATE:    rate_reg       <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (cmd.in_ld)
                last_vel_reg <= in_vel;
            if (cmd.out_ld)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // shared multiplier operands
    assign cos_val = (quad_reg == 2'd1 || quad_reg == 2'd2)
                   ? -$signed({1'b0, rom_q_reg}) : $signed({1'b0, rom_q_reg});

    always_comb
    begin
        case (cmd.mul_sel)
            pdtgf_pkg::MUL_DV:
            begin
                mul_a = 34'(dv_reg);
                mul_b = $signed({17'd0, rate_reg});
            end
            pdtgf_pkg::MUL_ANG:
            begin
                mul_a = 34'(angle_reg);
                mul_b = $signed({1'b0, pdtgf_pkg::TWO_OVER_PI_Q32});
            end
            pdtgf_pkg::MUL_INER:
            begin
                mul_a = accel_reg;
                mul_b = $signed({1'b0, inertia_reg});
            end
            pdtgf_pkg::MUL_FRIC:
            begin
                mul_a = 34'(vel_reg);
                mul_b = $signed({1'b0, friction_reg});
            end
            pdtgf_pkg::MUL_GRAV:
            begin
                mul_a = 34'(cos_val);
                mul_b = $signed({1'b0, gravity_reg});
            end
            pdtgf_pkg::MUL_PROP:
            begin
                mul_a = 34'(ea_reg);
                mul_b = $signed({1'b0, prop_gain_reg});
            end
            pdtgf_pkg::MUL_DERIV:
            begin
                mul_a = 34'(ev_reg);
                mul_b = $signed({1'b0, deriv_gain_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // quarter turns: quadrant above the fraction, fraction rounded to a table point
    assign frac     = prod_reg[F+31:F];
    assign rom_addr = quad_reg[0] ? (L+1)'(pdtgf_pkg::COS_TABLE_DEPTH) - idx_reg : idx_reg;
    assign term     = prod_reg[66:F];
    assign acc_sum  = acc_reg + 54'(term);

    always_ff @(posedge clk)
    begin
        prod_reg <= 67'(mul_a * mul_b);
        if (cmd.in_ld)
        begin
            angle_reg <= in_angle;
            vel_reg   <= in_vel;
            dv_reg    <= 33'(in_vel) - 33'($signed(last_vel_reg));
            ea_reg    <= 33'(in_angle_t) - 33'(in_angle);
            ev_reg    <= 33'(in_vel_t) - 33'(in_vel);
        end
        if (cmd.accel_ld)
        begin
            if (prod_reg > 67'sd4294967296)
                accel_reg <= 34'sd4294967296;
            else if (prod_reg < -67'sd4294967296)
                accel_reg <= -34'sd4294967296;
            else
                accel_reg <= prod_reg[33:0];
        end
        if (cmd.idx_ld)
        begin
            quad_reg <= prod_reg[F+33:F+32];
            idx_reg  <= {1'b0, frac[31:32-L]} + (L+1)'(frac[31-L]);
        end
        if (cmd.rom_rd)
            rom_q_reg <= pdtgf_pkg::COS_TAB[rom_addr];
        if (cmd.acc_first)
            acc_reg <= 54'(term);
        else if (cmd.acc_add)
            acc_reg <= acc_sum;
        if (cmd.out_ld)
        begin
            if (acc_sum > 54'sd2147483647)
            begin
                torque_reg <= 32'h7fff_ffff;
                sat_reg    <= 1'b1;
            end
            else if (acc_sum < -54'sd2147483648)
            begin
                torque_reg <= 32'h8000_0000;
                sat_reg    <= 1'b1;
            end
            else
            begin
                torque_reg <= acc_sum[31:0];
                sat_reg    <= 1'b0;
            end
        end
    end

    assign stat.out_full = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign out_torque    = torque_reg;
    assign out_sat       = sat_reg;

endmodule

// ===== sv/pd_torque_with_gravity_feedforward_unit.sv =====
// pd joint torque with gravity, friction and inertia feedforward
//
// s_* stream: one word per control sample (angle, velocity, angle_target,
// velocity_target, signed q16.16). m_* stream: one word per sample carrying
// the saturated torque in m_tdata and the clip flag in m_tuser.
// cfg_*: register writes (index 0..5: prop_gain, deriv_gain, gravity_coeff,
// friction_coeff, inertia_coeff, sample_rate); cfg_ready is always high,
// writes to unknown indexes are dropped
//
// the single shared 34x33 multiplier takes seven products in turn (accel,
// quarter-turn angle, then five torque terms), so a new sample is taken only
// once the previous one has moved into the output register;
// the result sits in an output register, so a new sample is accepted while
// it waits; if the receiver stalls, the next sample stops in its last step
// until the output register frees up
// reset: gains return to their defaults and the stored velocity to zero,
// so the first acceleration is velocity times sample_rate
module pd_torque_with_gravity_feedforward_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // angle, velocity, angle_target, velocity_target
    input  logic [127:0]                        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // torque
    output logic [31:0]                         m_tdata,
    // saturated
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pdtgf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                         cfg_data
);

    pdtgf_pkg::cmd_t  cmd;
    pdtgf_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    pdtgf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pdtgf_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_data    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_torque (m_tdata),
        .out_sat    (m_tuser)
    );

    // one sample in flight: no second accept right after one
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // a fresh result only appears when the controller was busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a sample");

    // the clip flag only goes with a rail value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 32'h7fff_ffff || m_tdata == 32'h8000_0000)
        else $error("saturated flag on unclipped torque");

endmodule
